/* rtl/lps_pkg.sv */
// package with shared types and constants for the lottery process scheduler
`timescale 1ns / 1ps

package lps_pkg;

    localparam int DEF_MAX_PROCS = 16;
    localparam int TAG_W         = 16;
    localparam int TIME_W        = 16;
    localparam int TICK_W        = 32;
    localparam int WEIGHT_W      = 2;
    localparam int RAND_W        = 31;
    localparam int MAX_WEIGHT    = 3;
    localparam int DIV_CNT_W     = $clog2(RAND_W + 1);
    localparam int ENTRY_W       = TAG_W + TIME_W + TIME_W + WEIGHT_W;
    localparam int S_FIELDS_W    = TAG_W + TIME_W + TIME_W + WEIGHT_W + RAND_W;
    localparam int S_TDATA_W     = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((TAG_W + TICK_W + 7) / 8) * 8;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        RPT_CHOSEN  = 2'd0,
        RPT_WAITING = 2'd1,
        RPT_IDLE    = 2'd2
    } rpt_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_SEARCH,
        ST_CHOSEN,
        ST_EMIT,
        ST_IDLE_RES
    } state_t;

    typedef struct packed {
        logic load;
        logic tick_start;
        logic sum_step;
        logic div_start;
        logic div_step;
        logic search_step;
        logic emit_chosen;
        logic emit_wait;
        logic emit_idle;
        logic idx_inc;
        logic tick_inc;
    } lps_cmd_t;

    typedef struct packed {
        logic at_end;
        logic total_zero;
        logic div_done;
        logic hit;
        logic skip;
        logic left_zero;
        logic out_free;
    } lps_sts_t;

endpackage

/* rtl/lps_ctrl.sv */
// controller state machine for the lottery process scheduler
`timescale 1ns / 1ps

module lps_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_kind,
    output logic             s_tready,
    input  lps_pkg::lps_sts_t sts,
    output lps_pkg::lps_cmd_t cmd
);
    import lps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_kind == KIND_TICK) begin
                        cmd.tick_start = 1'b1;
                        state_next     = ST_SUM;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SUM: begin
                if (sts.at_end) begin
                    if (sts.total_zero) begin
                        state_next = ST_IDLE_RES;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end else begin
                    cmd.sum_step = 1'b1;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_SEARCH;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_SEARCH: begin
                cmd.search_step = 1'b1;
                if (sts.hit) begin
                    state_next = ST_CHOSEN;
                end
            end
            ST_CHOSEN: begin
                if (sts.out_free) begin
                    cmd.emit_chosen = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.left_zero) begin
                    cmd.tick_inc = 1'b1;
                    state_next   = ST_IDLE;
                end else if (sts.skip) begin
                    cmd.idx_inc = 1'b1;
                end else if (sts.out_free) begin
                    cmd.emit_wait = 1'b1;
                end
            end
            ST_IDLE_RES: begin
                if (sts.out_free) begin
                    cmd.emit_idle = 1'b1;
                    cmd.tick_inc  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/lps_dp.sv */
// datapath with process table, ticket sums, modulo unit and result register
`timescale 1ns / 1ps

module lps_dp #(
    parameter int MAX_PROCS = lps_pkg::DEF_MAX_PROCS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [lps_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic [lps_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  lps_pkg::lps_cmd_t              cmd,
    output lps_pkg::lps_sts_t              sts
);
    import lps_pkg::*;

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int TOT_W = $clog2(MAX_WEIGHT * MAX_PROCS + 1);

    // input unpacking
    logic [TAG_W-1:0]    in_tag;
    logic [TIME_W-1:0]   in_arrival;
    logic [TIME_W-1:0]   in_run;
    logic [WEIGHT_W-1:0] in_weight;
    logic [RAND_W-1:0]   in_rand;

    assign in_tag     = s_tdata[TAG_W-1:0];
    assign in_arrival = s_tdata[TAG_W+TIME_W-1:TAG_W];
    assign in_run     = s_tdata[TAG_W+2*TIME_W-1:TAG_W+TIME_W];
    assign in_weight  = s_tdata[ENTRY_W-1:TAG_W+2*TIME_W];
    assign in_rand    = s_tdata[S_FIELDS_W-1:ENTRY_W];

    logic [ENTRY_W-1:0] mem [MAX_PROCS];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]     count_reg;
    logic [TICK_W-1:0]    tick_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     idx_next;
    logic [TOT_W-1:0]     total_reg;
    logic [CNT_W-1:0]     nelig_reg;
    logic [CNT_W-1:0]     left_reg;
    logic [RAND_W-1:0]    rand_reg;
    logic [TOT_W-1:0]     rem_reg;
    logic [TOT_W-1:0]     rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [TOT_W-1:0]     acc_reg;
    logic [TOT_W-1:0]     acc_next;
    logic [CNT_W-1:0]     win_idx_reg;
    logic [ENTRY_W-1:0]   win_entry_reg;

    logic                 m_valid_reg;
    rpt_kind_t            m_kind_reg;
    logic [TAG_W-1:0]     m_tag_reg;
    logic [TICK_W-1:0]    m_tick_reg;
    logic                 m_last_reg;

    // fields of the entry at idx_reg
    logic [TAG_W-1:0]    rd_tag;
    logic [TIME_W-1:0]   rd_arrival;
    logic [TIME_W-1:0]   rd_remain;
    logic [WEIGHT_W-1:0] rd_weight;
    logic                rd_elig;

    assign rd_tag     = rd_data_reg[TAG_W-1:0];
    assign rd_arrival = rd_data_reg[TAG_W+TIME_W-1:TAG_W];
    assign rd_remain  = rd_data_reg[TAG_W+2*TIME_W-1:TAG_W+TIME_W];
    assign rd_weight  = rd_data_reg[ENTRY_W-1:TAG_W+2*TIME_W];
    assign rd_elig    = (rd_remain != '0) && (TICK_W'(rd_arrival) <= tick_reg);

    logic                 load_ok;
    logic                 emit_any;
    logic [TOT_W:0]       rem_shift;
    logic [TOT_W:0]       rem_diff;
    logic [TIME_W-1:0]    win_remain_dec;

    assign load_ok  = cmd.load && (count_reg < CNT_W'(MAX_PROCS));
    assign emit_any = cmd.emit_chosen || cmd.emit_wait || cmd.emit_idle;

    // restoring remainder, one bit of the draw per cycle
    assign rem_shift = {rem_reg, rand_reg[RAND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, total_reg};
    assign rem_next  = (rem_shift >= {1'b0, total_reg}) ? rem_diff[TOT_W-1:0]
                                                        : rem_shift[TOT_W-1:0];

    assign acc_next = acc_reg + TOT_W'(rd_weight);
    assign win_remain_dec = win_entry_reg[TAG_W+2*TIME_W-1:TAG_W+TIME_W] - TIME_W'(1);

    always_comb begin
        idx_next = idx_reg;
        if (cmd.tick_start || cmd.div_start || cmd.emit_chosen) begin
            idx_next = '0;
        end else if (cmd.sum_step || cmd.search_step || cmd.emit_wait || cmd.idx_inc) begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    // table memory, read data registered from the next index
    always_ff @(posedge aclk) begin
        if (load_ok) begin
            mem[count_reg[IDX_W-1:0]] <= {in_weight, in_run, in_arrival, in_tag};
        end else if (cmd.emit_chosen) begin
            mem[win_idx_reg[IDX_W-1:0]] <= {win_entry_reg[ENTRY_W-1:TAG_W+2*TIME_W],
                                            win_remain_dec,
                                            win_entry_reg[TAG_W+TIME_W-1:0]};
        end
        rd_data_reg <= mem[idx_next[IDX_W-1:0]];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            tick_reg    <= TICK_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            if (load_ok) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.tick_inc) begin
                tick_reg <= tick_reg + TICK_W'(1);
            end
            if (emit_any) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.tick_start) begin
            rand_reg  <= in_rand;
            total_reg <= '0;
            nelig_reg <= '0;
        end
        if (cmd.sum_step && rd_elig) begin
            total_reg <= total_reg + TOT_W'(rd_weight);
            nelig_reg <= nelig_reg + CNT_W'(1);
        end
        if (cmd.div_start) begin
            rem_reg     <= '0;
            div_cnt_reg <= DIV_CNT_W'(RAND_W);
            acc_reg     <= '0;
        end
        if (cmd.div_step) begin
            rem_reg     <= rem_next;
            rand_reg    <= {rand_reg[RAND_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
        if (cmd.search_step && rd_elig) begin
            acc_reg <= acc_next;
            if (rem_reg < acc_next) begin
                win_idx_reg   <= idx_reg;
                win_entry_reg <= rd_data_reg;
            end
        end
        if (cmd.emit_chosen) begin
            left_reg <= nelig_reg - CNT_W'(1);
        end else if (cmd.emit_wait) begin
            left_reg <= left_reg - CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (emit_any) begin
            m_tick_reg <= tick_reg;
        end
        if (cmd.emit_chosen) begin
            m_kind_reg <= RPT_CHOSEN;
            m_tag_reg  <= win_entry_reg[TAG_W-1:0];
            m_last_reg <= (nelig_reg == CNT_W'(1));
        end else if (cmd.emit_wait) begin
            m_kind_reg <= RPT_WAITING;
            m_tag_reg  <= rd_tag;
            m_last_reg <= (left_reg == CNT_W'(1));
        end else if (cmd.emit_idle) begin
            m_kind_reg <= RPT_IDLE;
            m_tag_reg  <= '0;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = M_TDATA_W'({m_tick_reg, m_tag_reg});

    assign sts.at_end     = (idx_reg == count_reg);
    assign sts.total_zero = (total_reg == '0);
    assign sts.div_done   = (div_cnt_reg == '0);
    assign sts.hit        = rd_elig && (rem_reg < acc_next);
    assign sts.skip       = !rd_elig || (idx_reg == win_idx_reg);
    assign sts.left_zero  = (left_reg == '0);
    assign sts.out_free   = !m_valid_reg || m_tready;

endmodule

/* rtl/lottery_process_scheduler.sv */
// top level of the lottery process scheduler
//
//  channel   direction  tdata                                              tuser        tlast
//  s_        in         tag, arrival, run length, weight, random draw      kind         -
//  m_        out        report tag, tick time                              report kind  last
//
// a load transaction is taken in the idle state; a tick sums the tickets of the eligible
// entries, reduces the draw in the bit-serial modulo unit, searches for the winner, issues
// the winner and then the waiting entries, all through the single read port of the
// process table; a tick without tickets issues an idle result after the sum
// m_ stalls hold the current result and pause the third pass; no clearing pass after reset
`timescale 1ns / 1ps

module lottery_process_scheduler #(
    parameter int MAX_PROCS = lps_pkg::DEF_MAX_PROCS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // proc_tag, arrival_time, run_length, weight, random_value
    input  logic [lps_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // report_tag, tick_time
    output logic [lps_pkg::M_TDATA_W-1:0] m_tdata,
    // report_kind
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);
    import lps_pkg::*;

    lps_cmd_t cmd;
    lps_sts_t sts;

    lps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lps_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_chosen || cmd.emit_wait || cmd.emit_idle) |-> sts.out_free)
        else $error("result register overwritten while occupied");

    a_winner_found: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.search_step |-> !sts.at_end)
        else $error("winner search ran past the table");

    a_single_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_chosen, cmd.emit_wait, cmd.emit_idle}))
        else $error("more than one result issued in a cycle");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step || cmd.search_step) |-> !s_tready)
        else $error("input accepted during a tick");
`endif

endmodule

/* test/lottery_process_scheduler_test.sv */
// testbench for the lottery process scheduler: directed table, random ticks, self-checking
`timescale 1ns / 1ps

module lottery_process_scheduler_test;

    import lps_pkg::*;

    localparam int TABLE_DEPTH  = DEF_MAX_PROCS;
    localparam int RANDOM_TICKS = 96;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int STALL_LIMIT  = 3000;

    typedef struct {
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   arrival;
        logic [TIME_W-1:0]   remaining;
        logic [WEIGHT_W-1:0] weight;
        logic                done;
    } proc_entry_t;

    typedef struct packed {
        rpt_kind_t         kind;
        logic [TAG_W-1:0]  tag;
        logic [TICK_W-1:0] tick;
        logic              last;
    } sched_report_t;

    typedef struct {
        logic                kind;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   arrival;
        logic [TIME_W-1:0]   run_length;
        logic [WEIGHT_W-1:0] weight;
        logic [RAND_W-1:0]   draw;
        bit                  typed;
        rpt_kind_t           exp_kind;
        logic [TAG_W-1:0]    exp_tag;
        logic [TICK_W-1:0]   exp_tick;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    proc_entry_t     proc_table [TABLE_DEPTH];
    int unsigned     proc_count;
    logic [TICK_W-1:0] tick_now;
    sched_report_t   report_q [$];
    stim_row_t       plan_q [$];

    int  errors;
    int  results_checked;
    int  loads_sent;
    int  ticks_sent;
    bit  quiet;
    bit  hold_request;

    lottery_process_scheduler i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit proc_ready(input int idx);
        return !proc_table[idx].done && ({16'h0, proc_table[idx].arrival} <= tick_now);
    endfunction

    function automatic void schedule_step(input stim_row_t item, input bit keep);
        sched_report_t burst [$];
        int unsigned   tickets;
        int unsigned   draw;
        int unsigned   acc;
        int            winner;
        tickets = 0;
        acc     = 0;
        winner  = 0;
        if (item.kind == KIND_LOAD) begin
            if (proc_count < TABLE_DEPTH) begin
                proc_table[proc_count] = '{item.tag, item.arrival, item.run_length,
                                           item.weight, item.run_length == 0};
                proc_count++;
            end
            return;
        end
        for (int i = 0; i < proc_count; i++)
            if (proc_ready(i))
                tickets += proc_table[i].weight;
        if (tickets == 0) begin
            burst.push_back('{RPT_IDLE, 16'h0, tick_now, 1'b1});
        end else begin
            draw = item.draw % tickets;
            for (int i = 0; i < proc_count; i++) begin
                if (proc_ready(i)) begin
                    acc += proc_table[i].weight;
                    if (draw < acc) begin
                        winner = i;
                        break;
                    end
                end
            end
            burst.push_back('{RPT_CHOSEN, proc_table[winner].tag, tick_now, 1'b0});
            proc_table[winner].remaining--;
            if (proc_table[winner].remaining == 0)
                proc_table[winner].done = 1'b1;
            for (int i = 0; i < proc_count; i++)
                if (i != winner && proc_ready(i))
                    burst.push_back('{RPT_WAITING, proc_table[i].tag, tick_now, 1'b0});
            burst[burst.size() - 1].last = 1'b1;
        end
        tick_now++;
        if (keep)
            foreach (burst[i])
                report_q.push_back(burst[i]);
    endfunction

    task automatic add_row(input logic kind, input logic [15:0] tag, input logic [15:0] arrival,
                           input logic [15:0] run_length, input logic [1:0] weight,
                           input logic [30:0] draw, input bit typed, input rpt_kind_t exp_kind,
                           input logic [15:0] exp_tag, input logic [31:0] exp_tick);
        stim_row_t row;
        row = '{kind, tag, arrival, run_length, weight, draw, typed, exp_kind, exp_tag,
                exp_tick};
        plan_q.push_back(row);
    endtask

    task automatic send_item(input stim_row_t item);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= item.kind;
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, item.draw, item.weight,
                     item.run_length, item.arrival, item.tag};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (item.kind == KIND_LOAD)
            loads_sent++;
        else
            ticks_sent++;
        if (item.typed) begin
            schedule_step(item, 1'b0);
            report_q.push_back('{item.exp_kind, item.exp_tag, item.exp_tick, 1'b1});
        end else begin
            schedule_step(item, 1'b1);
        end
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        sched_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (report_q.size() == 0) begin
                report_mismatch("unexpected result tag", 32'(m_tdata[15:0]), 32'h0);
            end else begin
                want = report_q.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("report kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[TAG_W-1:0] !== want.tag)
                    report_mismatch("report tag", 32'(m_tdata[TAG_W-1:0]), 32'(want.tag));
                if (m_tdata[TAG_W+TICK_W-1:TAG_W] !== want.tick)
                    report_mismatch("tick time", m_tdata[TAG_W+TICK_W-1:TAG_W], want.tick);
                if (m_tlast !== want.last)
                    report_mismatch("last flag", 32'(m_tlast), 32'(want.last));
                results_checked++;
            end
        end
    end

    initial begin : watchdog
        int stall_count;
        stall_count = 0;
        while (stall_count < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_count = 0;
            else
                stall_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        stim_row_t item;
        int        n;
        errors          = 0;
        results_checked = 0;
        loads_sent      = 0;
        ticks_sent      = 0;
        quiet           = 1'b0;
        hold_request    = 1'b0;
        proc_count      = 0;
        tick_now        = 32'd1;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= KIND_LOAD;
        s_tdata  <= '0;

        // empty table, single winner, finished entry, zero run length and zero weight
        add_row(KIND_TICK, 16'h0, 16'h0, 16'h0, 2'd0, 31'h0, 1'b1, RPT_IDLE, 16'h0, 32'd1);
        add_row(KIND_LOAD, 16'hffff, 16'd0, 16'd1, 2'd3, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_TICK, 16'h0, 16'h0, 16'h0, 2'd0, 31'h7fffffff, 1'b1, RPT_CHOSEN,
                16'hffff, 32'd2);
        add_row(KIND_TICK, 16'h0, 16'h0, 16'h0, 2'd0, 31'h0, 1'b1, RPT_IDLE, 16'h0, 32'd3);
        add_row(KIND_LOAD, 16'h0000, 16'd0, 16'd0, 2'd2, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_LOAD, 16'h0001, 16'd0, 16'd3, 2'd0, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_TICK, 16'h0, 16'h0, 16'h0, 2'd0, 31'h1234, 1'b1, RPT_IDLE, 16'h0, 32'd4);
        // loads out of arrival order, up to a full table
        add_row(KIND_LOAD, 16'h0010, 16'hffff, 16'd5, 2'd3, 31'h0, 1'b0, RPT_IDLE, 16'h0,
                32'd0);
        add_row(KIND_LOAD, 16'h0020, 16'd40, 16'd4, 2'd2, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_LOAD, 16'h0030, 16'd0, 16'hffff, 2'd1, 31'h0, 1'b0, RPT_IDLE, 16'h0,
                32'd0);
        add_row(KIND_LOAD, 16'h0040, 16'd10, 16'd3, 2'd3, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_LOAD, 16'h0050, 16'd5, 16'd6, 2'd2, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_LOAD, 16'h0060, 16'd30, 16'd10, 2'd1, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_LOAD, 16'h0070, 16'd60, 16'd8, 2'd3, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_LOAD, 16'h0080, 16'd20, 16'd2, 2'd0, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_LOAD, 16'h0090, 16'd80, 16'd12, 2'd2, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_LOAD, 16'h00a0, 16'd100, 16'd30, 2'd3, 31'h0, 1'b0, RPT_IDLE, 16'h0,
                32'd0);
        add_row(KIND_LOAD, 16'h00b0, 16'd0, 16'd2, 2'd2, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_LOAD, 16'h5555, 16'd2, 16'd20, 2'd1, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_LOAD, 16'haaaa, 16'd50, 16'hffff, 2'd3, 31'h0, 1'b0, RPT_IDLE, 16'h0,
                32'd0);
        // table full: ignored
        add_row(KIND_LOAD, 16'h1234, 16'd0, 16'd9, 2'd3, 31'h0, 1'b0, RPT_IDLE, 16'h0, 32'd0);
        add_row(KIND_TICK, 16'h0, 16'h0, 16'h0, 2'd0, 31'h2aaaaaaa, 1'b0, RPT_IDLE, 16'h0,
                32'd0);
        add_row(KIND_TICK, 16'h0, 16'h0, 16'h0, 2'd0, 31'h55555555, 1'b0, RPT_IDLE, 16'h0,
                32'd0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan_q[i])
            send_item(plan_q[i]);

        n = 0;
        while (n < RANDOM_TICKS) begin
            item.kind       = ($urandom_range(0, 9) == 0) ? KIND_LOAD : KIND_TICK;
            item.tag        = TAG_W'($urandom);
            item.arrival    = TIME_W'($urandom);
            item.run_length = TIME_W'($urandom);
            item.weight     = WEIGHT_W'($urandom);
            item.draw       = ($urandom_range(0, 9) == 0) ? 31'h7fffffff : RAND_W'($urandom);
            item.typed      = 1'b0;
            item.exp_kind   = RPT_IDLE;
            item.exp_tag    = '0;
            item.exp_tick   = '0;
            if (item.kind == KIND_TICK) begin
                if (n == 30)
                    hold_request = 1'b1;
                if (n == 60) begin
                    s_tvalid <= 1'b0;
                    do
                        @(posedge aclk);
                    while (report_q.size() != 0);
                end
                if (n == 76)
                    quiet = 1'b1;
                n++;
            end
            send_item(item);
        end
        s_tvalid <= 1'b0;

        while (report_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d load and %0d tick transactions sent, %0d results checked",
                 loads_sent, ticks_sent, results_checked);
        $display("covered empty table, zero weight and run length, full table, %0d mismatches",
                 errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/lps_pkg.sv
rtl/lps_ctrl.sv
rtl/lps_dp.sv
rtl/lottery_process_scheduler.sv
test/lottery_process_scheduler_test.sv
